// ----- hdl/pcrb_pkg.sv -----
package pcrb_pkg;

    // Instruction size in bytes and the link register for BL
    localparam logic [63:0] INSN_BYTES = 64'd4;
    localparam logic [4:0]  LINK_REG   = 5'd30;

    // Opcode match values
    localparam logic [4:0] OP_ADR   = 5'b10000;      // bits 28:24
    localparam logic [5:0] OP_B     = 6'b000101;     // bits 31:26
    localparam logic [7:0] OP_BCOND = 8'b01010100;   // bits 31:24
    localparam logic [5:0] OP_BL    = 6'b100101;     // bits 31:26
    localparam logic [5:0] OP_CB    = 6'b011010;     // bits 30:25
    localparam logic [5:0] OP_TB    = 6'b011011;     // bits 30:25

    // Input beat: one instruction with its context
    typedef struct packed {
        logic [31:0] instruction;
        logic [63:0] pc;
        logic [63:0] operand_value;
        logic [3:0]  flags_nzcv;
    } t_in_beat;

    // Output beat: next counter and optional register write
    typedef struct packed {
        logic        recognized;
        logic [63:0] next_pc;
        logic        write_enable;
        logic [4:0]  write_index;
        logic [63:0] write_value;
    } t_out_beat;

endpackage

// ----- hdl/aarch64_pc_relative_branch_unit.sv -----
// PC-relative branch and address unit for 64-bit ARM code.
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one instruction
// beat: word, program counter, source register value and NZCV flags.
// Output channel (o_out_valid / i_out_ready / o_out_data) gives one beat per
// input: recognized flag, next program counter and an optional register
// write (ADR/ADRP address, or the BL return address into register 30).
// Pipeline: an accepted beat goes to the input register, then to the result
// register, i.e. two register stages (input register, result register) with
// one decode and one 64-bit target add between them.
// Throughput: one beat per cycle, sustained, as long as the receiver takes
// results; both stages advance together.
// Stall: when the receiver holds i_out_ready low, the result register holds
// and the input register still takes one more beat; o_in_ready then drops
// until the output drains.
// Reset (synchronous, active low) empties both stages; there is no other
// state.
module aarch64_pc_relative_branch_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pcrb_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pcrb_pkg::t_out_beat o_out_data
);

    logic                r_in_valid, n_in_valid;
    pcrb_pkg::t_in_beat  r_in;
    logic                r_out_valid, n_out_valid;
    pcrb_pkg::t_out_beat r_out;
    pcrb_pkg::t_out_beat exec_beat;
    logic                out_free, advance, in_take;

    // Handshake: result stage frees when empty or taken
    assign out_free   = ~r_out_valid | i_out_ready;
    assign advance    = r_in_valid & out_free;
    assign o_in_ready = ~r_in_valid | out_free;
    assign in_take    = i_in_valid & o_in_ready;

    assign n_in_valid  = in_take | (r_in_valid & ~out_free);
    assign n_out_valid = advance | (r_out_valid & ~i_out_ready);

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= exec_beat;
        end
    end

    pcrb_exec u_exec (
        .i_beat (r_in),
        .o_beat (exec_beat)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- hdl/pcrb_cond.sv -----
module pcrb_cond (
    input  logic [3:0] i_cond,
    input  logic [3:0] i_flags_nzcv,
    output logic       o_holds
);

    localparam logic [2:0] CC_EQ = 3'd0;
    localparam logic [2:0] CC_CS = 3'd1;
    localparam logic [2:0] CC_MI = 3'd2;
    localparam logic [2:0] CC_VS = 3'd3;
    localparam logic [2:0] CC_HI = 3'd4;
    localparam logic [2:0] CC_GE = 3'd5;
    localparam logic [2:0] CC_GT = 3'd6;
    localparam logic [3:0] CC_NV = 4'b1111;

    logic f_n, f_z, f_c, f_v;
    logic base;

    assign f_n = i_flags_nzcv[3];
    assign f_z = i_flags_nzcv[2];
    assign f_c = i_flags_nzcv[1];
    assign f_v = i_flags_nzcv[0];

    // Base condition from the upper three code bits
    always_comb begin
        case (i_cond[3:1])
            CC_EQ:   base = f_z;
            CC_CS:   base = f_c;
            CC_MI:   base = f_n;
            CC_VS:   base = f_v;
            CC_HI:   base = f_c & ~f_z;
            CC_GE:   base = (f_n == f_v);
            CC_GT:   base = ~f_z & (f_n == f_v);
            default: base = 1'b1;
        endcase
    end

    // Low bit inverts, except the always-code 1111
    assign o_holds = (i_cond[0] && (i_cond != CC_NV)) ? ~base : base;

endmodule

// ----- hdl/pcrb_exec.sv -----
module pcrb_exec (
    input  pcrb_pkg::t_in_beat  i_beat,
    output pcrb_pkg::t_out_beat o_beat
);

    logic [31:0] w;
    logic [63:0] pc;
    logic        is_adr, is_b, is_bcond, is_bl, is_cb, is_tb;
    logic        adr_hit, b_hit, bcond_hit, bl_hit, cb_hit, tb_hit;
    logic        cond_ok;
    logic [63:0] cb_val;
    logic        cb_take, tb_set, tb_take, take;
    logic [5:0]  tb_bit;
    logic [20:0] adr_imm;
    logic [63:0] base, offset, target, seq;

    assign w  = i_beat.instruction;
    assign pc = i_beat.pc;

    // Opcode matches, then priority in decode order
    assign is_adr   = (w[28:24] == pcrb_pkg::OP_ADR);
    assign is_b     = (w[31:26] == pcrb_pkg::OP_B);
    assign is_bcond = (w[31:24] == pcrb_pkg::OP_BCOND);
    assign is_bl    = (w[31:26] == pcrb_pkg::OP_BL);
    assign is_cb    = (w[30:25] == pcrb_pkg::OP_CB);
    assign is_tb    = (w[30:25] == pcrb_pkg::OP_TB);

    assign adr_hit   = is_adr;
    assign b_hit     = ~is_adr & is_b;
    assign bcond_hit = ~is_adr & ~is_b & is_bcond;
    assign bl_hit    = ~is_adr & ~is_b & ~is_bcond & is_bl;
    assign cb_hit    = ~is_adr & ~is_b & ~is_bcond & ~is_bl & is_cb;
    assign tb_hit    = ~is_adr & ~is_b & ~is_bcond & ~is_bl & ~is_cb & is_tb;

    pcrb_cond u_cond (
        .i_cond       (w[3:0]),
        .i_flags_nzcv (i_beat.flags_nzcv),
        .o_holds      (cond_ok)
    );

    // Compare-and-branch: 32-bit form looks at the low word only
    assign cb_val  = w[31] ? i_beat.operand_value : {32'd0, i_beat.operand_value[31:0]};
    assign cb_take = w[24] ? (cb_val != 64'd0) : (cb_val == 64'd0);

    // Test-and-branch: bit number b5:b40 over the full operand
    assign tb_bit  = {w[31], w[23:19]};
    assign tb_set  = i_beat.operand_value[tb_bit];
    assign tb_take = w[24] ? tb_set : ~tb_set;

    assign take = b_hit | bl_hit | (bcond_hit & cond_ok) | (cb_hit & cb_take)
                | (tb_hit & tb_take);

    // Offset and base select feed one shared target adder
    assign adr_imm = {w[23:5], w[30:29]};

    always_comb begin
        base   = pc;
        offset = 64'd0;
        if (adr_hit) begin
            if (w[31]) begin
                base   = {pc[63:12], 12'd0};
                offset = {{31{adr_imm[20]}}, adr_imm, 12'd0};
            end else begin
                offset = {{43{adr_imm[20]}}, adr_imm};
            end
        end else if (b_hit || bl_hit) begin
            offset = {{36{w[25]}}, w[25:0], 2'b00};
        end else if (tb_hit) begin
            offset = {{48{w[18]}}, w[18:5], 2'b00};
        end else begin
            offset = {{43{w[23]}}, w[23:5], 2'b00};
        end
    end

    assign target = base + offset;
    assign seq    = pc + pcrb_pkg::INSN_BYTES;

    // Result assembly
    always_comb begin
        o_beat.recognized   = adr_hit | b_hit | bcond_hit | bl_hit | cb_hit | tb_hit;
        o_beat.write_enable = adr_hit | bl_hit;
        o_beat.write_index  = 5'd0;
        o_beat.write_value  = 64'd0;
        if (adr_hit) begin
            o_beat.write_index = w[4:0];
            o_beat.write_value = target;
        end else if (bl_hit) begin
            o_beat.write_index = pcrb_pkg::LINK_REG;
            o_beat.write_value = seq;
        end
        if (!o_beat.recognized) begin
            o_beat.next_pc = pc;
        end else if (adr_hit) begin
            o_beat.next_pc = seq;
        end else if (take) begin
            o_beat.next_pc = target;
        end else begin
            o_beat.next_pc = seq;
        end
    end

endmodule
